FILE: design/fpsa_pkg.sv
// Package for the fixed pool slot allocator: operation and status codes,
// field widths, the sequencer state type and the structs shared by the modules.
// Depends on nothing; every other file of the block depends on it.
package fpsa_pkg;

	// Field widths of the request and response channels.
	localparam int OP_W   = 2;
	localparam int IDX_W  = 6;
	localparam int STAT_W = 3;
	localparam int SLOT_W = 5;
	localparam int USED_W = 6;

	// Default pool size.
	localparam int POOL_SIZE_DEF = 32;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_LIST    = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 3'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_USED  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd4;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC_RD,
		S_ALLOC_LINK,
		S_REL_CHK,
		S_REL_WALK,
		S_REL_FREE,
		S_REL_APPEND,
		S_LIST,
		S_EMIT
	} state_t;

	// Strobes from the sequencer to the link memory.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_busy;
	} mem_ctl_t;

	// One response item.
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
		logic              last;
		logic [USED_W-1:0] used_count;
	} rsp_t;

endpackage

FILE: design/fpsa_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on fpsa_pkg for the field widths.
interface fpsa_req_if;
	logic                          valid;
	logic                          ready;
	logic [fpsa_pkg::OP_W-1:0]     op;
	logic [fpsa_pkg::IDX_W-1:0]    slot_index;

	modport source (output valid, output op, output slot_index, input ready);
	modport sink   (input valid, input op, input slot_index, output ready);
endinterface

interface fpsa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [fpsa_pkg::STAT_W-1:0]   status;
	logic [fpsa_pkg::SLOT_W-1:0]   slot;
	logic                          last;
	logic [fpsa_pkg::USED_W-1:0]   used_count;

	modport source (output valid, output status, output slot, output last,
		output used_count, input ready);
	modport sink   (input valid, input status, input slot, input last,
		input used_count, output ready);
endinterface

FILE: design/fpsa_link_mem.sv
// Link memory: one entry per slot holding the busy flag and the next link.
// Depends on fpsa_pkg for the strobe struct.
module fpsa_link_mem #(
	parameter int POOL_SIZE = fpsa_pkg::POOL_SIZE_DEF,
	localparam int IW = $clog2(POOL_SIZE)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fpsa_pkg::mem_ctl_t ctl,
	input  logic [IW-1:0]      rd_addr,
	input  logic [IW-1:0]      wr_addr,
	input  logic [IW-1:0]      wr_link,
	output logic               rd_busy,
	output logic [IW-1:0]      rd_link
);
	import fpsa_pkg::*;

	localparam int EW = IW + 1;
	localparam logic [IW-1:0] LAST_ADDR = IW'(POOL_SIZE - 1);

	logic [EW-1:0]        mem_q [POOL_SIZE];
	logic [POOL_SIZE-1:0] valid_q;
	logic [EW-1:0]        rd_entry_q;
	logic                 rd_vld_q;
	logic [IW-1:0]        rd_dflt_q;
	logic [IW-1:0]        rd_dflt;

	// Reset contents of an entry: each slot links to the next, the final one to slot zero.
	assign rd_dflt = (rd_addr == LAST_ADDR) ? '0 : rd_addr + IW'(1);

	// Write port and registered read port; the read data holds until the next read.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= {ctl.wr_busy, wr_link};
		end
		if (ctl.rd_en) begin
			rd_entry_q <= mem_q[rd_addr];
			rd_vld_q   <= valid_q[rd_addr];
			rd_dflt_q  <= rd_dflt;
		end
	end

	// An entry that was never written since reset reads as its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_busy = rd_vld_q ? rd_entry_q[IW] : 1'b0;
	assign rd_link = rd_vld_q ? rd_entry_q[IW-1:0] : rd_dflt_q;

endmodule

FILE: design/fpsa_ctrl.sv
// Sequencer of the allocator: list pointers, counts, the read-modify-write
// walk over the link memory and the response register.
// Depends on fpsa_pkg for codes, the state type and the structs.
module fpsa_ctrl #(
	parameter int POOL_SIZE = fpsa_pkg::POOL_SIZE_DEF,
	localparam int IW = $clog2(POOL_SIZE)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [fpsa_pkg::OP_W-1:0]  in_op,
	input  logic [fpsa_pkg::IDX_W-1:0] in_idx,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output fpsa_pkg::rsp_t             rsp,
	output fpsa_pkg::mem_ctl_t         mem_ctl,
	output logic [IW-1:0]              rd_addr,
	output logic [IW-1:0]              wr_addr,
	output logic [IW-1:0]              wr_link,
	input  logic                       rd_busy,
	input  logic [IW-1:0]              rd_link
);
	import fpsa_pkg::*;

	localparam int CW   = $clog2(POOL_SIZE + 1);
	localparam int CMPW = (IW + 1 > IDX_W) ? IW + 1 : IDX_W;

	state_t            state_q, state_d;
	logic [IW-1:0]     slot_q, slot_d;
	logic [IW-1:0]     ptr_q, ptr_d;
	logic [IW-1:0]     link_s_q, link_s_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [STAT_W-1:0] stat_q, stat_d;
	logic [IW-1:0]     free_first_q, free_first_d;
	logic [IW-1:0]     free_final_q, free_final_d;
	logic [CW-1:0]     free_total_q, free_total_d;
	logic [IW-1:0]     busy_first_q, busy_first_d;
	logic [IW-1:0]     busy_final_q, busy_final_d;
	logic [CW-1:0]     busy_total_q, busy_total_d;
	rsp_t              rsp_q, rsp_d;
	logic              rsp_valid_q, rsp_valid_d;

	logic              out_free;
	logic              idx_oor;
	logic [CW-1:0]     cnt_inc;
	logic              list_last;

	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign idx_oor   = CMPW'(in_idx) >= CMPW'(POOL_SIZE);
	assign cnt_inc   = cnt_q + CW'(1);
	assign list_last = (cnt_inc == busy_total_q);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Next state, memory strobes and next register values.
	always_comb begin
		state_d      = state_q;
		slot_d       = slot_q;
		ptr_d        = ptr_q;
		link_s_d     = link_s_q;
		cnt_d        = cnt_q;
		stat_d       = stat_q;
		free_first_d = free_first_q;
		free_final_d = free_final_q;
		free_total_d = free_total_q;
		busy_first_d = busy_first_q;
		busy_final_d = busy_final_q;
		busy_total_d = busy_total_q;
		rsp_d        = rsp_q;
		rsp_valid_d  = rsp_valid_q && !rsp_ready;
		mem_ctl      = '0;
		rd_addr      = '0;
		wr_addr      = '0;
		wr_link      = '0;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_op)
						OP_ALLOC: begin
							if (free_total_q == '0) begin
								stat_d  = STAT_EXHAUSTED;
								slot_d  = '0;
								state_d = S_EMIT;
							end else begin
								slot_d        = free_first_q;
								mem_ctl.rd_en = 1'b1;
								rd_addr       = free_first_q;
								state_d       = S_ALLOC_RD;
							end
						end
						OP_RELEASE: begin
							if (idx_oor) begin
								stat_d  = STAT_RANGE;
								slot_d  = '0;
								state_d = S_EMIT;
							end else begin
								slot_d        = IW'(in_idx);
								mem_ctl.rd_en = 1'b1;
								rd_addr       = IW'(in_idx);
								state_d       = S_REL_CHK;
							end
						end
						OP_LIST: begin
							if (busy_total_q == '0) begin
								stat_d  = STAT_EMPTY;
								slot_d  = '0;
								state_d = S_EMIT;
							end else begin
								ptr_d         = busy_first_q;
								cnt_d         = '0;
								mem_ctl.rd_en = 1'b1;
								rd_addr       = busy_first_q;
								state_d       = S_LIST;
							end
						end
						default: begin
							// An undefined operation is taken and dropped.
						end
					endcase
				end
			end

			// Pop the free head and mark the slot busy with a cleared link.
			S_ALLOC_RD: begin
				free_first_d    = rd_link;
				free_total_d    = free_total_q - CW'(1);
				mem_ctl.wr_en   = 1'b1;
				mem_ctl.wr_busy = 1'b1;
				wr_addr         = slot_q;
				wr_link         = '0;
				state_d         = S_ALLOC_LINK;
			end

			// Append the slot at the tail of the in-use list.
			S_ALLOC_LINK: begin
				if (busy_total_q != '0) begin
					mem_ctl.wr_en   = 1'b1;
					mem_ctl.wr_busy = 1'b1;
					wr_addr         = busy_final_q;
					wr_link         = slot_q;
				end else begin
					busy_first_d = slot_q;
				end
				busy_final_d = slot_q;
				busy_total_d = busy_total_q + CW'(1);
				stat_d       = STAT_OK;
				state_d      = S_EMIT;
			end

			// Check the slot and either report it not in use, unlink it at the head or start the walk.
			S_REL_CHK: begin
				link_s_d = rd_link;
				if (!rd_busy || busy_total_q == '0) begin
					stat_d  = STAT_NOT_USED;
					state_d = S_EMIT;
				end else if (busy_first_q == slot_q) begin
					busy_first_d = rd_link;
					if (busy_total_q == CW'(1)) begin
						busy_final_d = '0;
					end
					state_d = S_REL_FREE;
				end else if (busy_total_q > CW'(1)) begin
					ptr_d         = busy_first_q;
					cnt_d         = CW'(1);
					mem_ctl.rd_en = 1'b1;
					rd_addr       = busy_first_q;
					state_d       = S_REL_WALK;
				end else begin
					stat_d  = STAT_NOT_USED;
					state_d = S_EMIT;
				end
			end

			// Follow the in-use chain one link per cycle to find the predecessor.
			S_REL_WALK: begin
				if (rd_link == slot_q) begin
					mem_ctl.wr_en   = 1'b1;
					mem_ctl.wr_busy = 1'b1;
					wr_addr         = ptr_q;
					wr_link         = link_s_q;
					if (busy_final_q == slot_q) begin
						busy_final_d = ptr_q;
					end
					state_d = S_REL_FREE;
				end else begin
					ptr_d = rd_link;
					cnt_d = cnt_inc;
					if (cnt_inc < busy_total_q) begin
						mem_ctl.rd_en = 1'b1;
						rd_addr       = rd_link;
					end else begin
						stat_d  = STAT_NOT_USED;
						state_d = S_EMIT;
					end
				end
			end

			// Clear the released entry.
			S_REL_FREE: begin
				mem_ctl.wr_en   = 1'b1;
				mem_ctl.wr_busy = 1'b0;
				wr_addr         = slot_q;
				wr_link         = '0;
				busy_total_d    = busy_total_q - CW'(1);
				state_d         = S_REL_APPEND;
			end

			// Append the released slot at the tail of the free list.
			S_REL_APPEND: begin
				if (free_total_q != '0) begin
					mem_ctl.wr_en   = 1'b1;
					mem_ctl.wr_busy = 1'b0;
					wr_addr         = free_final_q;
					wr_link         = slot_q;
				end else begin
					free_first_d = slot_q;
				end
				free_final_d = slot_q;
				free_total_d = free_total_q + CW'(1);
				stat_d       = STAT_OK;
				state_d      = S_EMIT;
			end

			// Stream the in-use slots, one per transfer, fetching the next link ahead.
			S_LIST: begin
				if (out_free) begin
					rsp_valid_d      = 1'b1;
					rsp_d.status     = STAT_OK;
					rsp_d.slot       = SLOT_W'(ptr_q);
					rsp_d.last       = list_last;
					rsp_d.used_count = USED_W'(busy_total_q);
					if (list_last) begin
						state_d = S_IDLE;
					end else begin
						ptr_d         = rd_link;
						cnt_d         = cnt_inc;
						mem_ctl.rd_en = 1'b1;
						rd_addr       = rd_link;
					end
				end
			end

			// Single result of an allocate, a release or an error.
			S_EMIT: begin
				if (out_free) begin
					rsp_valid_d      = 1'b1;
					rsp_d.status     = stat_q;
					rsp_d.slot       = SLOT_W'(slot_q);
					rsp_d.last       = 1'b1;
					rsp_d.used_count = USED_W'(busy_total_q);
					state_d          = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// List pointers, counts and the response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_first_q <= '0;
			free_final_q <= IW'(POOL_SIZE - 1);
			free_total_q <= CW'(POOL_SIZE);
			busy_first_q <= '0;
			busy_final_q <= '0;
			busy_total_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			free_first_q <= free_first_d;
			free_final_q <= free_final_d;
			free_total_q <= free_total_d;
			busy_first_q <= busy_first_d;
			busy_final_q <= busy_final_d;
			busy_total_q <= busy_total_d;
			rsp_valid_q  <= rsp_valid_d;
		end
	end

	// Working registers of the current operation and the response payload.
	always_ff @(posedge clk) begin
		slot_q   <= slot_d;
		ptr_q    <= ptr_d;
		link_s_q <= link_s_d;
		cnt_q    <= cnt_d;
		stat_q   <= stat_d;
		rsp_q    <= rsp_d;
	end

endmodule

FILE: design/fixed_pool_slot_allocator_unit.sv
// Top level of the fixed pool slot allocator: request and response channels,
// the sequencer and the link memory. Depends on fpsa_pkg, fpsa_if.sv,
// fpsa_link_mem and fpsa_ctrl.

// A pool of POOL_SIZE slots is kept as a free list and an in-use list that
// share one link memory with a registered read. A request is taken only while
// the sequencer is idle; a result waits in the response register and does not
// stop the next request from being taken. Allocate reads the free head, marks
// the slot busy, appends it to the in-use list and then gives its result.
// Release checks the slot and unlinks it at the head, or else walks the chain
// through the memory one read per cycle to find its predecessor and relinks
// that; it then clears the entry and appends it to the free list. List fetches
// the head, then gives one result per cycle while the response side is ready.
// Pool exhausted, index out of range and an empty list skip the memory; a
// slot not in use is read before it is reported. No clearing pass is needed
// after reset: per-entry valid flags give untouched entries their reset links.
module fixed_pool_slot_allocator_unit #(
	parameter int POOL_SIZE = fpsa_pkg::POOL_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fpsa_req_if.sink    req,
	fpsa_rsp_if.source  rsp
);
	import fpsa_pkg::*;

	localparam int IW = $clog2(POOL_SIZE);

	mem_ctl_t      mem_ctl;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] wr_link;
	logic          rd_busy;
	logic [IW-1:0] rd_link;
	rsp_t          rsp_item;
	logic          rsp_valid;

	// Sequencer.
	fpsa_ctrl #(
		.POOL_SIZE (POOL_SIZE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_op     (req.op),
		.in_idx    (req.slot_index),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.rsp       (rsp_item),
		.mem_ctl   (mem_ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.wr_link   (wr_link),
		.rd_busy   (rd_busy),
		.rd_link   (rd_link)
	);

	// Link and busy memory.
	fpsa_link_mem #(
		.POOL_SIZE (POOL_SIZE)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_link (wr_link),
		.rd_busy (rd_busy),
		.rd_link (rd_link)
	);

	// Response channel.
	assign rsp.valid      = rsp_valid;
	assign rsp.status     = rsp_item.status;
	assign rsp.slot       = rsp_item.slot;
	assign rsp.last       = rsp_item.last;
	assign rsp.used_count = rsp_item.used_count;

`ifndef SYNTHESIS
	// The sequencer never reads and writes the memory in the same cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_ctl.rd_en && mem_ctl.wr_en))
		else $error("link memory read and written in the same cycle");

	// Every write stays inside the pool.
	a_wr_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.wr_en |-> ({1'b0, wr_addr} < (IW + 1)'(POOL_SIZE)))
		else $error("link memory write beyond the pool");

	// Every read stays inside the pool.
	a_rd_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.rd_en |-> ({1'b0, rd_addr} < (IW + 1)'(POOL_SIZE)))
		else $error("link memory read beyond the pool");

	// A result with last low, which only a non-final listing transfer gives, must carry an OK status.
	a_not_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.last) |-> (rsp.status == STAT_OK))
		else $error("non-final result with an error status");
`endif

endmodule

FILE: test/testbench.sv
// Testbench for fixed_pool_slot_allocator_unit: a stimulus table, then random allocate, release
// and list traffic, each result checked against its typed row or a software copy of both lists.
// Depends on fpsa_pkg, the channel interfaces in fpsa_if.sv and the RTL of the unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import fpsa_pkg::*;

	localparam int NSLOT = POOL_SIZE_DEF;
	localparam int LATENCY = NSLOT + 8;
	localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

	// One row of the stimulus table; typed rows carry their single result.
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		logic [5:0]       reps;
		logic             typed;
		rsp_t             want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	fpsa_req_if req_if();
	fpsa_rsp_if rsp_if();

	fixed_pool_slot_allocator_unit #(.POOL_SIZE(NSLOT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// Software copy of the pool: shared link table, busy flags and both list heads.
	logic [SLOT_W-1:0] next_slot [NSLOT];
	logic              in_use [NSLOT];
	logic [SLOT_W-1:0] free_head, free_tail, used_head, used_tail;
	int free_cnt, used_cnt;

	rsp_t      step_results[$];
	rsp_t      results_due[$];
	stim_row_t stim_rows[$];

	int send_idle_pct = 36;
	int recv_stall_pct = 85;
	int fail_count = 0;
	int results_seen = 0;
	int requests_done = 0;
	int exhaust_hits = 0;
	int peak_used = 0;
	int list_walks = 0;

	// Free-running clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic rsp_t slot_rsp(input logic [STAT_W-1:0] st, input logic [SLOT_W-1:0] sl,
		input logic ls);
		rsp_t r;
		r.status = st;
		r.slot = sl;
		r.last = ls;
		r.used_count = used_cnt[USED_W-1:0];
		return r;
	endfunction

	function automatic void pool_reset();
		for (int i = 0; i < NSLOT; i++) begin
			next_slot[i] = SLOT_W'((i + 1) % NSLOT);
			in_use[i] = 1'b0;
		end
		free_head = '0;
		free_tail = SLOT_W'(NSLOT - 1);
		free_cnt = NSLOT;
		used_head = '0;
		used_tail = '0;
		used_cnt = 0;
	endfunction

	// Applies one request to the pool copy and leaves its results in step_results.
	function automatic void pool_step(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
		logic [SLOT_W-1:0] s, p, nx;
		logic found;
		step_results.delete();
		s = idx[SLOT_W-1:0];
		found = 1'b0;
		case (op)
			OP_ALLOC: begin
				if (free_cnt == 0) begin
					exhaust_hits++;
					step_results.push_back(slot_rsp(STAT_EXHAUSTED, '0, 1'b1));
				end else begin
					s = free_head;
					free_head = next_slot[s];
					free_cnt--;
					next_slot[s] = '0;
					in_use[s] = 1'b1;
					if (used_cnt == 0)
						used_head = s;
					else
						next_slot[used_tail] = s;
					used_tail = s;
					used_cnt++;
					if (used_cnt > peak_used)
						peak_used = used_cnt;
					step_results.push_back(slot_rsp(STAT_OK, s, 1'b1));
				end
			end
			OP_RELEASE: begin
				if (idx >= NSLOT) begin
					step_results.push_back(slot_rsp(STAT_RANGE, '0, 1'b1));
				end else if (!in_use[s] || used_cnt == 0) begin
					step_results.push_back(slot_rsp(STAT_NOT_USED, s, 1'b1));
				end else begin
					// Unlink from the in-use list, walking to the predecessor if needed.
					if (used_head == s) begin
						found = 1'b1;
						used_head = next_slot[s];
						if (used_cnt == 1)
							used_tail = '0;
					end else begin
						p = used_head;
						for (int n = 1; n < used_cnt && !found; n++) begin
							nx = next_slot[p];
							if (nx == s)
								found = 1'b1;
							else
								p = nx;
						end
						if (found) begin
							next_slot[p] = next_slot[s];
							if (used_tail == s)
								used_tail = p;
						end
					end
					if (!found) begin
						step_results.push_back(slot_rsp(STAT_NOT_USED, s, 1'b1));
					end else begin
						used_cnt--;
						in_use[s] = 1'b0;
						next_slot[s] = '0;
						if (free_cnt == 0)
							free_head = s;
						else
							next_slot[free_tail] = s;
						free_tail = s;
						free_cnt++;
						step_results.push_back(slot_rsp(STAT_OK, s, 1'b1));
					end
				end
			end
			OP_LIST: begin
				if (used_cnt == 0) begin
					step_results.push_back(slot_rsp(STAT_EMPTY, '0, 1'b1));
				end else begin
					list_walks++;
					p = used_head;
					for (int n = 0; n < used_cnt; n++) begin
						step_results.push_back(slot_rsp(STAT_OK, p, n + 1 == used_cnt));
						p = next_slot[p];
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void add_row(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
		input int reps, input logic typed, input logic [STAT_W-1:0] st,
		input logic [SLOT_W-1:0] sl, input int uc);
		stim_row_t row;
		row.op = op;
		row.idx = idx;
		row.reps = 6'(reps);
		row.typed = typed;
		row.want.status = st;
		row.want.slot = sl;
		row.want.last = 1'b1;
		row.want.used_count = USED_W'(uc);
		stim_rows.push_back(row);
	endfunction

	// Offers one request, waits for its transfer and queues the results it is due to cause.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
		input logic typed, input rsp_t want);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		req_if.valid <= 1'b1;
		req_if.op <= op;
		req_if.slot_index <= idx;
		do
			@(posedge clk);
		while (!req_if.ready);
		requests_done++;
		pool_step(op, idx);
		if (typed) begin
			results_due.push_back(want);
		end else begin
			for (int i = 0; i < step_results.size(); i++)
				results_due.push_back(step_results[i]);
		end
	endtask

	// Response side: random stalls, and each transfer checked against the oldest expectation.
	initial begin
		rsp_t want;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				results_seen++;
				if (results_due.size() == 0) begin
					$display("%0t ns: unexpected result status=%0d slot=%0d last=%0d used=%0d",
						$time, rsp_if.status, rsp_if.slot, rsp_if.last, rsp_if.used_count);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					if (rsp_if.status !== want.status || rsp_if.slot !== want.slot ||
						rsp_if.last !== want.last || rsp_if.used_count !== want.used_count) begin
						$display("%0t ns: mismatch expected status=%0d slot=%0d last=%0d used=%0d",
							$time, want.status, want.slot, want.last, want.used_count);
						$display("%0t ns:          actual status=%0d slot=%0d last=%0d used=%0d",
							$time, rsp_if.status, rsp_if.slot, rsp_if.last, rsp_if.used_count);
						fail_count++;
					end
				end
			end
			rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Stimulus: reset, the directed table, then three phases of random traffic.
	initial begin
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		logic             picked;
		int               r, start, n_sent;
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.op <= OP_ALLOC;
		req_if.slot_index <= '0;
		pool_reset();

		// Errors on an empty pool, filling to exhaustion, then unlinking at head, tail and middle.
		add_row(OP_LIST,    6'd0,  1, 1'b1, STAT_EMPTY,     5'd0,  0);
		add_row(OP_RELEASE, 6'd63, 1, 1'b1, STAT_RANGE,     5'd0,  0);
		add_row(OP_RELEASE, 6'd32, 1, 1'b1, STAT_RANGE,     5'd0,  0);
		add_row(OP_RELEASE, 6'd0,  1, 1'b1, STAT_NOT_USED,  5'd0,  0);
		add_row(OP_UNDEF,   6'd21, 1, 1'b0, STAT_OK,        5'd0,  0);
		add_row(OP_ALLOC,   6'd0,  1, 1'b1, STAT_OK,        5'd0,  1);
		add_row(OP_RELEASE, 6'd31, 1, 1'b1, STAT_NOT_USED,  5'd31, 1);
		add_row(OP_ALLOC,   6'd0, 31, 1'b0, STAT_OK,        5'd0,  0);
		add_row(OP_ALLOC,   6'd0,  1, 1'b1, STAT_EXHAUSTED, 5'd0,  32);
		add_row(OP_UNDEF,   6'd42, 1, 1'b0, STAT_OK,        5'd0,  0);
		add_row(OP_LIST,    6'd0,  1, 1'b0, STAT_OK,        5'd0,  0);
		add_row(OP_RELEASE, 6'd0,  1, 1'b0, STAT_OK,        5'd0,  0);
		add_row(OP_RELEASE, 6'd31, 1, 1'b0, STAT_OK,        5'd0,  0);
		add_row(OP_RELEASE, 6'd17, 1, 1'b0, STAT_OK,        5'd0,  0);
		add_row(OP_RELEASE, 6'd17, 1, 1'b1, STAT_NOT_USED,  5'd17, 29);
		add_row(OP_ALLOC,   6'd0,  1, 1'b0, STAT_OK,        5'd0,  0);
		add_row(OP_LIST,    6'd0,  1, 1'b0, STAT_OK,        5'd0,  0);
		add_row(OP_RELEASE, 6'd40, 1, 1'b1, STAT_RANGE,     5'd0,  30);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < stim_rows.size(); i++) begin
			repeat (stim_rows[i].reps)
				send_request(stim_rows[i].op, stim_rows[i].idx, stim_rows[i].typed,
					stim_rows[i].want);
		end

		// Mostly allocates and releases of busy slots, with lists, stray indexes and bad opcodes.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 85 : 0;
			recv_stall_pct = (ph == 0) ? 85 : (ph == 1) ? 36 : 0;
			n_sent = 0;
			while (n_sent < 17) begin
				r = $urandom_range(0, 99);
				idx = IDX_W'($urandom_range(0, 63));
				if (r < 38) begin
					op = OP_ALLOC;
				end else if (r < 70 && used_cnt > 0) begin
					op = OP_RELEASE;
					picked = 1'b0;
					start = $urandom_range(0, NSLOT - 1);
					for (int k = 0; k < NSLOT; k++) begin
						if (!picked && in_use[(start + k) % NSLOT]) begin
							idx = IDX_W'((start + k) % NSLOT);
							picked = 1'b1;
						end
					end
				end else if (r < 82) begin
					op = OP_LIST;
				end else if (r < 94) begin
					op = OP_RELEASE;
				end else begin
					op = OP_UNDEF;
				end
				send_request(op, idx, 1'b0, '0);
				if (op != OP_UNDEF)
					n_sent++;
			end
		end

		// Drain, then allow for any stray result before the verdict.
		req_if.valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
		$display("Run covered %0d requests and %0d results: %0d list walks, %0d exhausted pools,",
			requests_done, results_seen, list_walks, exhaust_hits);
		$display("peak in-use count %0d, %0d failures.", peak_used, fail_count);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("Timeout with %0d results still outstanding.", results_due.size());
		$display("testbench: FAIL");
		$finish;
	end

endmodule
